// File: rtl/qtu_pkg.sv
// ----------------------------------------------------------------------------
// qtu_pkg
// Word types, field widths, codes and limits shared by the Q-table engine.
// ----------------------------------------------------------------------------
package qtu_pkg;

    localparam int Q_W       = 24;
    localparam int LR_W      = 16;
    localparam int DF_W      = 15;
    localparam int SU_W      = 4;
    localparam int AU_W      = 3;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [Q_W-1:0] Q_MAX = 24'sh7FFFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 24'sh800000;

    localparam logic [1:0] FUNC_UPDATE = 2'd0;
    localparam logic [1:0] FUNC_QUERY  = 2'd1;
    localparam logic [1:0] FUNC_WRITE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STATES_USED  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIONS_USED = 2'd3;

    typedef struct packed {
        logic [1:0]            func;
        logic [2:0]            cur_state;
        logic [2:0]            next_state;
        logic [1:0]            act;
        logic signed [Q_W-1:0] reward_or_value;
    } req_word_t;

    typedef struct packed {
        logic                  status;
        logic [1:0]            best_action;
        logic signed [Q_W-1:0] value_out;
    } rsp_word_t;

    typedef struct packed {
        logic mul1_en;
        logic diff_en;
        logic mul2_en;
    } upd_ctrl_t;

endpackage

// File: rtl/qtu_mem.sv
// ----------------------------------------------------------------------------
// qtu_mem
// Q-table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module qtu_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [qtu_pkg::Q_W-1:0]   wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [qtu_pkg::Q_W-1:0]   rdata
);

    logic [qtu_pkg::Q_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/qtu_update.sv
// ----------------------------------------------------------------------------
// qtu_update
// Update arithmetic: discounted max, temporal difference and learning-rate
// scaling, each a registered step, then a combinational saturating add.
// ----------------------------------------------------------------------------
module qtu_update (
    input  logic                             clk,
    input  qtu_pkg::upd_ctrl_t               ctrl,
    input  logic [qtu_pkg::LR_W-1:0]         learn_rate,
    input  logic [qtu_pkg::DF_W-1:0]         discount,
    input  logic signed [qtu_pkg::Q_W-1:0]   max_value,
    input  logic signed [qtu_pkg::Q_W-1:0]   entry_value,
    input  logic signed [qtu_pkg::Q_W-1:0]   reward,
    output logic signed [qtu_pkg::Q_W-1:0]   new_value
);

    logic signed [qtu_pkg::Q_W-1:0]  t_reg, t_next;
    logic signed [qtu_pkg::Q_W-1:0]  cur_reg;
    logic signed [qtu_pkg::Q_W+1:0]  d_reg, d_next;
    logic signed [qtu_pkg::Q_W+3:0]  u_reg, u_next;
    logic signed [qtu_pkg::Q_W+15:0] prod1;
    logic signed [qtu_pkg::Q_W+18:0] prod2;
    logic signed [qtu_pkg::Q_W+4:0]  sum;

    // floor shifts: arithmetic right shift by 15
    assign prod1  = $signed({1'b0, discount}) * max_value;
    assign t_next = prod1[qtu_pkg::Q_W+14:15];

    assign d_next = 26'(reward) + 26'(t_reg) - 26'(cur_reg);

    assign prod2  = $signed({1'b0, learn_rate}) * d_reg;
    assign u_next = prod2[qtu_pkg::Q_W+18:15];

    assign sum = 29'(cur_reg) + 29'(u_reg);

    always_comb
    begin
        if (sum > 29'(qtu_pkg::Q_MAX))
        begin
            new_value = qtu_pkg::Q_MAX;
        end
        else if (sum < 29'(qtu_pkg::Q_MIN))
        begin
            new_value = qtu_pkg::Q_MIN;
        end
        else
        begin
            new_value = sum[qtu_pkg::Q_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul1_en)
        begin
            t_reg   <= t_next;
            cur_reg <= entry_value;
        end
        if (ctrl.diff_en)
        begin
            d_reg <= d_next;
        end
        if (ctrl.mul2_en)
        begin
            u_reg <= u_next;
        end
    end

endmodule

// File: rtl/q_table_update_engine_top.sv
// updates and queries scan na = min(actions_used, MAX_ACTIONS) row entries,
//   one entry a cycle; write and rejected words go straight to ST_DONE
// req_stall is high in every state but ST_IDLE, so one word is in flight at a time
// reset: a clearing pass zeroes all MAX_STATES*MAX_ACTIONS table entries,
//   req_stall high meanwhile; configuration writes are taken throughout
// ----------------------------------------------------------------------------
// q_table_update_engine_top
// Tabular Q-learning engine: sequencer, configuration, table and result word.
// ----------------------------------------------------------------------------
module q_table_update_engine_top #(
    parameter int MAX_STATES  = 8,
    parameter int MAX_ACTIONS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  qtu_pkg::req_word_t              req_word,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output qtu_pkg::rsp_word_t              rsp_word,
    input  logic                            cfg_we,
    input  logic [qtu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qtu_pkg::CFG_W-1:0]       cfg_data
);

    localparam int DEPTH = MAX_STATES * MAX_ACTIONS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b00000001,
        ST_IDLE  = 8'b00000010,
        ST_SCAN  = 8'b00000100,
        ST_LAST  = 8'b00001000,
        ST_MUL1  = 8'b00010000,
        ST_DIFF  = 8'b00100000,
        ST_MUL2  = 8'b01000000,
        ST_DONE  = 8'b10000000
    } state_t;

    state_t                           state_reg, state_next;
    logic [qtu_pkg::LR_W-1:0]         lr_reg, lr_next;
    logic [qtu_pkg::DF_W-1:0]         df_reg, df_next;
    logic [qtu_pkg::SU_W-1:0]         su_reg, su_next;
    logic [qtu_pkg::AU_W-1:0]         au_reg, au_next;
    logic [AW-1:0]                    clr_reg, clr_next;
    logic [2:0]                       issue_reg, issue_next;
    logic                             rsp_valid_reg, rsp_valid_next;
    qtu_pkg::rsp_word_t               rsp_word_reg, rsp_word_next;

    logic [1:0]                       op_reg, op_next;
    logic                             ok_reg, ok_next;
    logic [2:0]                       row_reg, row_next;
    logic [AW-1:0]                    ent_reg, ent_next;
    logic signed [qtu_pkg::Q_W-1:0]   rv_reg, rv_next;
    logic [qtu_pkg::AU_W-1:0]         na_reg, na_next;
    logic signed [qtu_pkg::Q_W-1:0]   bv_reg, bv_next;
    logic [1:0]                       best_reg, best_next;

    logic [qtu_pkg::AU_W-1:0]         na_lim;
    logic                             s_ok, sn_ok, a_ok;
    logic [2:0]                       cmp_idx;
    logic                             cmp_en;
    logic                             rsp_free;
    logic                             mem_we, mem_re;
    logic [AW-1:0]                    mem_waddr, mem_raddr, scan_addr;
    logic signed [qtu_pkg::Q_W-1:0]   mem_wdata, mem_rdata, upd_value;
    qtu_pkg::upd_ctrl_t               upd_ctrl;

    assign na_lim = (32'(au_reg) < MAX_ACTIONS) ? au_reg : qtu_pkg::AU_W'(MAX_ACTIONS);
    assign s_ok   = ({1'b0, req_word.cur_state} < su_reg) &&
                    (32'(req_word.cur_state) < MAX_STATES);
    assign sn_ok  = ({1'b0, req_word.next_state} < su_reg) &&
                    (32'(req_word.next_state) < MAX_STATES);
    assign a_ok   = ({1'b0, req_word.act} < na_lim);

    assign scan_addr = AW'(32'(row_reg) * 32'(MAX_ACTIONS) + 32'(issue_reg));
    assign cmp_idx   = issue_reg - 3'd1;
    assign cmp_en    = ((state_reg == ST_SCAN) && (issue_reg != 3'd0)) ||
                       (state_reg == ST_LAST);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    assign upd_ctrl.mul1_en = (state_reg == ST_MUL1);
    assign upd_ctrl.diff_en = (state_reg == ST_DIFF);
    assign upd_ctrl.mul2_en = (state_reg == ST_MUL2);

    qtu_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    qtu_update u_update (
        .clk         (clk),
        .ctrl        (upd_ctrl),
        .learn_rate  (lr_reg),
        .discount    (df_reg),
        .max_value   (bv_reg),
        .entry_value (mem_rdata),
        .reward      (rv_reg),
        .new_value   (upd_value)
    );

    always_comb
    begin
        lr_next = lr_reg;
        df_next = df_reg;
        su_next = su_reg;
        au_next = au_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                qtu_pkg::CFG_LEARN_RATE:   lr_next = cfg_data;
                qtu_pkg::CFG_DISCOUNT:     df_next = cfg_data[qtu_pkg::DF_W-1:0];
                qtu_pkg::CFG_STATES_USED:  su_next = cfg_data[qtu_pkg::SU_W-1:0];
                qtu_pkg::CFG_ACTIONS_USED: au_next = cfg_data[qtu_pkg::AU_W-1:0];
                default:                   lr_next = lr_reg;
            endcase
        end
    end

    always_comb
    begin
        mem_re = 1'b0;
        mem_raddr = scan_addr;
        if (state_reg == ST_SCAN)
        begin
            mem_re = 1'b1;
        end
        else if (state_reg == ST_LAST)
        begin
            mem_re    = (op_reg == qtu_pkg::FUNC_UPDATE);
            mem_raddr = ent_reg;
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ent_reg;
        mem_wdata = rv_reg;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else if ((state_reg == ST_DONE) && rsp_free && ok_reg)
        begin
            if (op_reg == qtu_pkg::FUNC_UPDATE)
            begin
                mem_we    = 1'b1;
                mem_wdata = upd_value;
            end
            else if (op_reg == qtu_pkg::FUNC_WRITE)
            begin
                mem_we = 1'b1;
            end
        end
    end

    // running greedy search over the row, ties keep the lower index
    always_comb
    begin
        bv_next   = bv_reg;
        best_next = best_reg;
        if (cmp_en)
        begin
            if (cmp_idx == 3'd0)
            begin
                bv_next   = mem_rdata;
                best_next = 2'd0;
            end
            else if (bv_reg < mem_rdata)
            begin
                bv_next   = mem_rdata;
                best_next = cmp_idx[1:0];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        issue_next = issue_reg;
        op_next    = op_reg;
        ok_next    = ok_reg;
        row_next   = row_reg;
        ent_next   = ent_reg;
        rv_next    = rv_reg;
        na_next    = na_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req_word.func;
                    rv_next    = req_word.reward_or_value;
                    na_next    = na_lim;
                    issue_next = 3'd0;
                    ent_next   = AW'(32'(req_word.cur_state) * 32'(MAX_ACTIONS) +
                                     32'(req_word.act));
                    row_next   = req_word.cur_state;
                    case (req_word.func)
                        qtu_pkg::FUNC_UPDATE:
                        begin
                            ok_next  = s_ok && sn_ok && a_ok;
                            row_next = req_word.next_state;
                        end
                        qtu_pkg::FUNC_QUERY: ok_next = s_ok && (na_lim != '0);
                        qtu_pkg::FUNC_WRITE: ok_next = s_ok && a_ok;
                        default:             ok_next = 1'b0;
                    endcase
                    if (ok_next && ((req_word.func == qtu_pkg::FUNC_UPDATE) ||
                                    (req_word.func == qtu_pkg::FUNC_QUERY)))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                issue_next = issue_reg + 3'd1;
                if (issue_reg == na_reg - 3'd1)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = (op_reg == qtu_pkg::FUNC_UPDATE) ? ST_MUL1 : ST_DONE;
            end
            ST_MUL1: state_next = ST_DIFF;
            ST_DIFF: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_DONE;
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        rsp_word_next = '0;
        rsp_word_next.status = 1'b1;
        if (ok_reg)
        begin
            rsp_word_next.status = 1'b0;
            case (op_reg)
                qtu_pkg::FUNC_UPDATE:
                begin
                    rsp_word_next.best_action = best_reg;
                    rsp_word_next.value_out   = upd_value;
                end
                qtu_pkg::FUNC_QUERY:
                begin
                    rsp_word_next.best_action = best_reg;
                    rsp_word_next.value_out   = bv_reg;
                end
                qtu_pkg::FUNC_WRITE: rsp_word_next.value_out = rv_reg;
                default:             rsp_word_next.status = 1'b1;
            endcase
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if ((state_reg == ST_DONE) && rsp_free)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            issue_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            lr_reg        <= 16'd9830;
            df_reg        <= 15'd16384;
            su_reg        <= 4'd8;
            au_reg        <= 3'd3;
            op_reg        <= qtu_pkg::FUNC_UPDATE;
            ok_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            issue_reg     <= issue_next;
            rsp_valid_reg <= rsp_valid_next;
            lr_reg        <= lr_next;
            df_reg        <= df_next;
            su_reg        <= su_next;
            au_reg        <= au_next;
            op_reg        <= op_next;
            ok_reg        <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        ent_reg  <= ent_next;
        rv_reg   <= rv_next;
        na_reg   <= na_next;
        bv_reg   <= bv_next;
        best_reg <= best_next;
        if ((state_reg == ST_DONE) && rsp_free)
        begin
            rsp_word_reg <= rsp_word_next;
        end
    end

`ifndef SYNTHESIS
    a_write_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && (state_reg != ST_CLEAR)) |-> ((state_reg == ST_DONE) && ok_reg))
        else $error("table written outside a finished request");

    a_done_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && rsp_valid_reg && rsp_stall) |=> (state_reg == ST_DONE))
        else $error("result word overwritten while stalled");

    a_reject_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_word_reg.status) |->
        ((rsp_word_reg.best_action == 2'd0) && (rsp_word_reg.value_out == '0)))
        else $error("rejected word carries a payload");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> ((state_reg == ST_SCAN) || (state_reg == ST_DONE)))
        else $error("accepted word not started");
`endif

endmodule
